@@ rtl/bounded_deque_top_defines.svh @@
// ----------------------------------------------------------------------------
// bounded deque assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_TOP_DEFINES_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bounded deque package
// request opcodes and result status codes
// ----------------------------------------------------------------------------
package bdq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } bdq_op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } bdq_status_t;

endpackage

@@ rtl/bdq_ring_mem.sv @@
// ----------------------------------------------------------------------------
// bounded deque ring memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bdq_ring_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(DEPTH)-1:0]      waddr,
  input  logic signed [DATA_WIDTH-1:0]  wdata,
  input  logic                          re,
  input  logic [$clog2(DEPTH)-1:0]      raddr,
  output logic signed [DATA_WIDTH-1:0]  rdata
);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bounded deque controller
// pointers, count, cached end values and result registers
// ----------------------------------------------------------------------------
`include "bounded_deque_top_defines.svh"

module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_op,
  input  logic signed [DATA_WIDTH-1:0]     in_value,
  output logic                             out_valid,
  output logic signed [DATA_WIDTH-1:0]     out_popped,
  output bdq_status_t                      out_status,
  output logic [$clog2(DEPTH+1)-1:0]       out_occupancy,
  output logic                             out_is_empty,
  output logic signed [DATA_WIDTH-1:0]     out_front_value,
  output logic signed [DATA_WIDTH-1:0]     out_back_value,
  output logic                             mem_we,
  output logic [$clog2(DEPTH)-1:0]         mem_waddr,
  output logic signed [DATA_WIDTH-1:0]     mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(DEPTH)-1:0]         mem_raddr,
  input  logic signed [DATA_WIDTH-1:0]     mem_rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           head_r, head_nxt;
  logic [PW-1:0]           tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [DATA_WIDTH-1:0] front_r, front_nxt;
  logic signed [DATA_WIDTH-1:0] back_r, back_nxt;
  logic                    fetch_front_r, fetch_front_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_popped_r, out_popped_nxt;
  bdq_status_t             out_status_r, out_status_nxt;
  logic [CW-1:0]           out_occ_r, out_occ_nxt;
  logic signed [DATA_WIDTH-1:0] out_front_r, out_front_nxt;
  logic signed [DATA_WIDTH-1:0] out_back_r, out_back_nxt;
  logic                    accept;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_LAST : p - PW'(1);
  endfunction

  assign busy   = (state_r == ST_FETCH);
  assign accept = start && !busy;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    back_nxt        = back_r;
    fetch_front_nxt = fetch_front_r;
    out_valid_nxt   = 1'b0;
    out_popped_nxt  = out_popped_r;
    out_status_nxt  = out_status_r;
    out_occ_nxt     = out_occ_r;
    out_front_nxt   = out_front_r;
    out_back_nxt    = out_back_r;
    mem_we          = 1'b0;
    mem_waddr       = head_r;
    mem_wdata       = in_value;
    mem_re          = 1'b0;
    mem_raddr       = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_popped_nxt = '0;
          out_status_nxt = STAT_OK;
          out_valid_nxt  = 1'b1;
          unique case (bdq_op_t'(in_op))
            OP_PUSH_FRONT: begin
              if (count_r == CNT_FULL) begin
                out_status_nxt = STAT_FULL;
              end else begin
                head_nxt  = ptr_dec(head_r);
                mem_we    = 1'b1;
                mem_waddr = ptr_dec(head_r);
                front_nxt = in_value;
                if (count_r == '0) begin
                  back_nxt = in_value;
                end
                count_nxt = count_r + CNT_ONE;
              end
            end
            OP_PUSH_BACK: begin
              if (count_r == CNT_FULL) begin
                out_status_nxt = STAT_FULL;
              end else begin
                tail_nxt  = ptr_inc(tail_r);
                mem_we    = 1'b1;
                mem_waddr = ptr_inc(tail_r);
                back_nxt  = in_value;
                if (count_r == '0) begin
                  front_nxt = in_value;
                end
                count_nxt = count_r + CNT_ONE;
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_popped_nxt = front_r;
                head_nxt       = ptr_inc(head_r);
                count_nxt      = count_r - CNT_ONE;
                if (count_r > CNT_ONE) begin
                  mem_re          = 1'b1;
                  mem_raddr       = ptr_inc(head_r);
                  fetch_front_nxt = 1'b1;
                  out_valid_nxt   = 1'b0;
                  state_nxt       = ST_FETCH;
                end
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_popped_nxt = back_r;
                tail_nxt       = ptr_dec(tail_r);
                count_nxt      = count_r - CNT_ONE;
                if (count_r > CNT_ONE) begin
                  mem_re          = 1'b1;
                  mem_raddr       = ptr_dec(tail_r);
                  fetch_front_nxt = 1'b0;
                  out_valid_nxt   = 1'b0;
                  state_nxt       = ST_FETCH;
                end
              end
            end
          endcase
          out_occ_nxt   = count_nxt;
          out_front_nxt = (count_nxt == '0) ? '0 : front_nxt;
          out_back_nxt  = (count_nxt == '0) ? '0 : back_nxt;
        end
      end
      ST_FETCH: begin
        // new end value arrives from the ring memory
        if (fetch_front_r) begin
          front_nxt = mem_rdata;
        end else begin
          back_nxt = mem_rdata;
        end
        out_front_nxt = front_nxt;
        out_back_nxt  = back_nxt;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= PTR_LAST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    front_r       <= front_nxt;
    back_r        <= back_nxt;
    fetch_front_r <= fetch_front_nxt;
    out_popped_r  <= out_popped_nxt;
    out_status_r  <= out_status_nxt;
    out_occ_r     <= out_occ_nxt;
    out_front_r   <= out_front_nxt;
    out_back_r    <= out_back_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_popped      = out_popped_r;
  assign out_status      = out_status_r;
  assign out_occupancy   = out_occ_r;
  assign out_is_empty    = (out_occ_r == '0);
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;

  `BDQ_ASSERT_NEXT(a_fetch_one_cycle, state_r == ST_FETCH,
                   out_valid_r && state_r == ST_IDLE, "fetch did not complete in one cycle")
  `BDQ_ASSERT_NEXT(a_request_answered, accept,
                   out_valid_r || state_r == ST_FETCH, "request produced no result path")
  `BDQ_ASSERT_NOW(a_empty_ptrs, count_r == '0,
                  tail_r == ptr_dec(head_r), "empty queue pointers out of step")
  `BDQ_ASSERT_NOW(a_fetch_nonempty, state_r == ST_FETCH,
                  count_r != '0, "fetch pending on empty queue")

endmodule

@@ rtl/bounded_deque_top.sv @@
// result strobe the cycle after a push, a rejected request or a pop that empties the queue
// for a pop that leaves elements, one ring memory read fetches the new end value while
// busy is high in the fetch state, and the result strobe is then registered from that state
// one request per cycle while busy is low; busy holds off requests during such a fetch
// synchronous reset zeroes head, count, state and strobe and sets tail to DEPTH-1; memory contents are kept
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
// bounded deque top level
// double-ended queue held in a ring memory with head and tail pointers
// ----------------------------------------------------------------------------
module bounded_deque_top
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_op,
  input  logic signed [DATA_WIDTH-1:0]     in_value,
  output logic                             out_valid,
  output logic signed [DATA_WIDTH-1:0]     out_popped,
  output bdq_status_t                      out_status,
  output logic [$clog2(DEPTH+1)-1:0]       out_occupancy,
  output logic                             out_is_empty,
  output logic signed [DATA_WIDTH-1:0]     out_front_value,
  output logic signed [DATA_WIDTH-1:0]     out_back_value
);

  localparam int PW = $clog2(DEPTH);

  logic                         mem_we;
  logic [PW-1:0]                mem_waddr;
  logic signed [DATA_WIDTH-1:0] mem_wdata;
  logic                         mem_re;
  logic [PW-1:0]                mem_raddr;
  logic signed [DATA_WIDTH-1:0] mem_rdata;

  bdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_popped      (out_popped),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy),
    .out_is_empty    (out_is_empty),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  bdq_ring_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
